@@ src/mavt_pkg.sv @@
// Shared types and constants for the multi-turn angle and velocity tracker.
package mavt_pkg;

    localparam int CPR_W   = 15;
    localparam int TIME_W  = 32;
    localparam int ANGLE_W = 32;
    localparam int VEL_W   = 32;
    localparam int DT_W    = 19;
    localparam int DIFF_W  = ANGLE_W + 1;
    localparam int SCALE_W = 20;
    localparam int NUM_W   = DIFF_W + SCALE_W;
    localparam int QUO_W   = VEL_W + 1;

    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_ANGLE = 2'd1;
    localparam logic [1:0] FUNC_VEL   = 2'd2;

    localparam logic [CPR_W-1:0]   CPR_RESET   = 15'd16384;
    localparam logic [SCALE_W-1:0] VEL_SCALE   = 20'd1000000;
    localparam logic [TIME_W-1:0]  DT_LIMIT    = 32'd500000;
    localparam logic [DT_W-1:0]    DT_FALLBACK = 19'd1000;
    localparam logic [VEL_W-1:0]   VEL_MAX     = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0]   VEL_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ src/mavt_div.sv @@
// Restoring shift-subtract divider, one quotient bit per cycle, with overflow detect.
module mavt_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  mavt_pkg::div_req_t req,
    output mavt_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(mavt_pkg::QUO_W);
    localparam int HI_W  = mavt_pkg::NUM_W - mavt_pkg::QUO_W;

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic                         ovf_reg, ovf_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [mavt_pkg::DT_W-1:0]    rem_reg, rem_next;
    logic [mavt_pkg::DT_W-1:0]    dvs_reg, dvs_next;
    logic [mavt_pkg::QUO_W-1:0]   quo_reg, quo_next;

    logic [mavt_pkg::DT_W:0]      trial;
    logic [mavt_pkg::DT_W:0]      trial_sub;
    logic                         trial_ge;
    logic                         start_ovf;

    assign trial     = {rem_reg, quo_reg[mavt_pkg::QUO_W-1]};
    assign trial_ge  = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign start_ovf = req.dividend[mavt_pkg::NUM_W-1 -: HI_W]
                       >= HI_W'({1'b0, req.divisor});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (busy_reg) begin
            rem_next = trial_ge ? trial_sub[mavt_pkg::DT_W-1:0] : trial[mavt_pkg::DT_W-1:0];
            quo_next = {quo_reg[mavt_pkg::QUO_W-2:0], trial_ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            dvs_next = req.divisor;
            ovf_next = start_ovf;
            rem_next = req.dividend[mavt_pkg::NUM_W-2 -: mavt_pkg::DT_W];
            quo_next = req.dividend[mavt_pkg::QUO_W-1:0];
            cnt_next = CNT_W'(mavt_pkg::QUO_W - 1);
            if (start_ovf) begin
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.ovf      = ovf_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ src/multiturn_angle_velocity_tracker.sv @@
// Multi-turn angle unwrap and velocity tracker for an absolute single-turn encoder.
// One item is processed at a time: an angle-only or initialize item passes through the
// TRACK, ANGLE and OUT states, a velocity item also through DIFF, MUL, LOAD and DIV,
// where the bit-serial divider produces 33 quotient bits one per cycle (none when the
// quotient overflows and the result saturates at once).
// s_tready is high only while the sequencer is idle, which it reenters as the result
// is presented; a finished result sits in the output register until taken, so the
// next input can be accepted meanwhile, and the following result waits for it.
// velocity_cps = (angle - angle at last velocity item) * 1e6 / dt, truncated toward
// zero and saturated; dt falls back to 1000 us when zero or above 500000 us.
module multiturn_angle_velocity_tracker #(
    parameter int RAW_BITS  = 14,
    parameter int TURN_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mavt_pkg::CPR_W-1:0]            cfg_data,   // counts_per_rev
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((RAW_BITS+32+7)/8)*8-1:0]      s_tdata,    // raw_count, time_us
    input  logic [1:0]                            s_tuser,    // func
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [63:0]                           m_tdata,    // angle_counts, velocity_cps
    output logic                                  m_tuser     // velocity_valid
);

    localparam int CMP_W  = (RAW_BITS + 3 > mavt_pkg::CPR_W + 2) ? RAW_BITS + 3
                                                                  : mavt_pkg::CPR_W + 2;
    localparam int PROD_W = TURN_BITS + mavt_pkg::CPR_W + 1;
    localparam int SUM_W  = (PROD_W + 1 > mavt_pkg::ANGLE_W) ? PROD_W + 1
                                                             : mavt_pkg::ANGLE_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TRACK = 8'b0000_0010,
        S_ANGLE = 8'b0000_0100,
        S_DIFF  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_LOAD  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t                             state_reg, state_next;
    logic [mavt_pkg::CPR_W-1:0]         cpr_reg, cpr_next;
    logic [RAW_BITS-1:0]                prev_raw_reg, prev_raw_next;
    logic signed [TURN_BITS-1:0]        turn_reg, turn_next;
    logic [mavt_pkg::ANGLE_W-1:0]       prev_angle_reg, prev_angle_next;
    logic [mavt_pkg::TIME_W-1:0]        prev_time_reg, prev_time_next;
    logic                               m_valid_reg, m_valid_next;

    logic [1:0]                         func_reg, func_next;
    logic [RAW_BITS-1:0]                raw_reg, raw_next;
    logic [mavt_pkg::TIME_W-1:0]        time_reg, time_next;
    logic [mavt_pkg::DT_W-1:0]          dt_reg, dt_next;
    logic [mavt_pkg::ANGLE_W-1:0]       angle_reg, angle_next;
    logic                               neg_reg, neg_next;
    logic [mavt_pkg::DIFF_W-1:0]        dmag_reg, dmag_next;
    logic [mavt_pkg::NUM_W-1:0]         num_reg, num_next;
    logic [mavt_pkg::VEL_W-1:0]         vel_reg, vel_next;
    logic                               vvalid_reg, vvalid_next;
    logic [63:0]                        m_data_reg, m_data_next;
    logic                               m_user_reg, m_user_next;

    logic signed [RAW_BITS:0]           d;
    logic [RAW_BITS:0]                  d_neg;
    logic [RAW_BITS-1:0]                mag;
    logic [CMP_W-1:0]                   mag5;
    logic [CMP_W-1:0]                   cpr4;
    logic                               jump;
    logic [mavt_pkg::TIME_W-1:0]        dt_raw;
    logic signed [PROD_W-1:0]           prod;
    logic signed [SUM_W-1:0]            angle_sum;
    logic signed [mavt_pkg::DIFF_W-1:0] diff;
    logic [mavt_pkg::DIFF_W-1:0]        diff_neg;
    logic [mavt_pkg::QUO_W-1:0]         q;
    logic [mavt_pkg::VEL_W-1:0]         q_neg;
    logic                               sat;
    logic                               out_free;

    mavt_pkg::div_req_t                 div_req;
    mavt_pkg::div_rsp_t                 div_rsp;

    mavt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign out_free  = !m_valid_reg || m_tready;

    assign d     = $signed({1'b0, raw_reg}) - $signed({1'b0, prev_raw_reg});
    assign d_neg = -d;
    assign mag   = d[RAW_BITS] ? d_neg[RAW_BITS-1:0] : d[RAW_BITS-1:0];
    assign mag5  = (CMP_W'(mag) << 2) + CMP_W'(mag);
    assign cpr4  = CMP_W'(cpr_reg) << 2;
    assign jump  = mag5 > cpr4;

    assign dt_raw = time_reg - prev_time_reg;

    assign prod      = turn_reg * $signed({1'b0, cpr_reg});
    assign angle_sum = SUM_W'(prod) + SUM_W'($signed({1'b0, prev_raw_reg}));

    assign diff     = $signed({angle_reg[mavt_pkg::ANGLE_W-1], angle_reg})
                    - $signed({prev_angle_reg[mavt_pkg::ANGLE_W-1], prev_angle_reg});
    assign diff_neg = -diff;

    assign q     = div_rsp.quotient;
    assign q_neg = -q[mavt_pkg::VEL_W-1:0];
    assign sat   = div_rsp.ovf
                 | (neg_reg ? (q[mavt_pkg::VEL_W] | (q[mavt_pkg::VEL_W-1]
                                                    & (|q[mavt_pkg::VEL_W-2:0])))
                            : (q[mavt_pkg::VEL_W] | q[mavt_pkg::VEL_W-1]));

    assign div_req.start    = (state_reg == S_LOAD);
    assign div_req.dividend = num_reg;
    assign div_req.divisor  = dt_reg;

    always_comb begin
        state_next      = state_reg;
        cpr_next        = cpr_reg;
        prev_raw_next   = prev_raw_reg;
        turn_next       = turn_reg;
        prev_angle_next = prev_angle_reg;
        prev_time_next  = prev_time_reg;
        m_valid_next    = m_valid_reg;
        func_next       = func_reg;
        raw_next        = raw_reg;
        time_next       = time_reg;
        dt_next         = dt_reg;
        angle_next      = angle_reg;
        neg_next        = neg_reg;
        dmag_next       = dmag_reg;
        num_next        = num_reg;
        vel_next        = vel_reg;
        vvalid_next     = vvalid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;

        if (cfg_valid && cfg_ready) begin
            cpr_next = cfg_data;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    raw_next   = s_tdata[RAW_BITS-1:0];
                    time_next  = s_tdata[RAW_BITS +: mavt_pkg::TIME_W];
                    state_next = S_TRACK;
                end
            end
            S_TRACK: begin
                if (dt_raw == '0 || dt_raw > mavt_pkg::DT_LIMIT) begin
                    dt_next = mavt_pkg::DT_FALLBACK;
                end else begin
                    dt_next = dt_raw[mavt_pkg::DT_W-1:0];
                end
                unique case (func_reg) inside
                    mavt_pkg::FUNC_INIT: begin
                        turn_next       = '0;
                        prev_angle_next = '0;
                        prev_raw_next   = raw_reg;
                        prev_time_next  = time_reg;
                    end
                    mavt_pkg::FUNC_ANGLE, mavt_pkg::FUNC_VEL: begin
                        if (jump) begin
                            turn_next = d[RAW_BITS] ? turn_reg + 1'b1 : turn_reg - 1'b1;
                        end
                        prev_raw_next = raw_reg;
                    end
                    default: begin
                    end
                endcase
                state_next = S_ANGLE;
            end
            S_ANGLE: begin
                angle_next  = angle_sum[mavt_pkg::ANGLE_W-1:0];
                vel_next    = '0;
                vvalid_next = 1'b0;
                state_next  = (func_reg == mavt_pkg::FUNC_VEL) ? S_DIFF : S_OUT;
            end
            S_DIFF: begin
                neg_next   = diff[mavt_pkg::DIFF_W-1];
                dmag_next  = diff[mavt_pkg::DIFF_W-1] ? diff_neg : diff;
                state_next = S_MUL;
            end
            S_MUL: begin
                num_next   = dmag_reg * mavt_pkg::VEL_SCALE;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (sat) begin
                        vel_next = neg_reg ? mavt_pkg::VEL_MIN : mavt_pkg::VEL_MAX;
                    end else begin
                        vel_next = neg_reg ? q_neg : q[mavt_pkg::VEL_W-1:0];
                    end
                    vvalid_next     = 1'b1;
                    prev_angle_next = angle_reg;
                    prev_time_next  = time_reg;
                    state_next      = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_data_next  = {vel_reg, angle_reg};
                    m_user_next  = vvalid_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cpr_reg        <= mavt_pkg::CPR_RESET;
            prev_raw_reg   <= '0;
            turn_reg       <= '0;
            prev_angle_reg <= '0;
            prev_time_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cpr_reg        <= cpr_next;
            prev_raw_reg   <= prev_raw_next;
            turn_reg       <= turn_next;
            prev_angle_reg <= prev_angle_next;
            prev_time_reg  <= prev_time_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        raw_reg    <= raw_next;
        time_reg   <= time_next;
        dt_reg     <= dt_next;
        angle_reg  <= angle_next;
        neg_reg    <= neg_next;
        dmag_reg   <= dmag_next;
        num_reg    <= num_next;
        vel_reg    <= vel_next;
        vvalid_reg <= vvalid_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

@@ src/mavt_checker.sv @@
// Port-level checks for the multi-turn angle and velocity tracker, bound to the top level.
module mavt_checker #(
    parameter int RAW_BITS = 14
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [((RAW_BITS+32+7)/8)*8-1:0] s_tdata,
    input logic [1:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [63:0]                      m_tdata,
    input logic                             m_tuser
);

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_busy_after_in: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid |-> !$isunknown({s_tuser, s_tdata}))
        else $error("unknown bits on an offered input transfer");

    a_vel_zero_unless_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[63:32] == 32'd0)
        else $error("nonzero velocity without velocity_valid");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind multiturn_angle_velocity_tracker mavt_checker #(.RAW_BITS(RAW_BITS)) u_mavt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
